### hw/rtl/aaou_pkg.sv
// Shared types and constants for the axis-angle orientation update block.
`default_nettype none
package aaou_pkg;
  localparam int CORDIC_Q = 30;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  typedef logic signed [15:0] ent_t;

  typedef struct packed {
    logic       req_type;
    ent_t       axis_x;
    ent_t       axis_y;
    ent_t       axis_z;
    logic [15:0] turn_angle;
    logic [1:0] row_index;
    ent_t       load_x;
    ent_t       load_y;
    ent_t       load_z;
  } req_t;

  typedef struct packed {
    ent_t m11; ent_t m12; ent_t m13;
    ent_t m21; ent_t m22; ent_t m23;
    ent_t m31; ent_t m32; ent_t m33;
  } res_t;

  // CORDIC start/done handshake between top and rotator
  typedef struct packed {
    logic start;
    logic done;
  } cordic_ctl_t;

  function automatic logic signed [31:0] atan_lut(input logic [5:0] i);
    logic signed [31:0] v;
    begin
      case (i)
        6'd0: v = 32'sd536870912;  6'd1: v = 32'sd316933406;
        6'd2: v = 32'sd167458907;  6'd3: v = 32'sd85004756;
        6'd4: v = 32'sd42667331;   6'd5: v = 32'sd21354465;
        6'd6: v = 32'sd10679838;   6'd7: v = 32'sd5340245;
        6'd8: v = 32'sd2670163;    6'd9: v = 32'sd1335087;
        6'd10: v = 32'sd667544;    6'd11: v = 32'sd333772;
        6'd12: v = 32'sd166886;    6'd13: v = 32'sd83443;
        6'd14: v = 32'sd41722;     6'd15: v = 32'sd20861;
        6'd16: v = 32'sd10430;     6'd17: v = 32'sd5215;
        6'd18: v = 32'sd2608;      6'd19: v = 32'sd1304;
        6'd20: v = 32'sd652;       6'd21: v = 32'sd326;
        6'd22: v = 32'sd163;       6'd23: v = 32'sd81;
        6'd24: v = 32'sd41;        6'd25: v = 32'sd20;
        6'd26: v = 32'sd10;        6'd27: v = 32'sd5;
        6'd28: v = 32'sd3;         6'd29: v = 32'sd1;
        6'd30: v = 32'sd1;
        default: v = 32'sd0;
      endcase
      return v;
    end
  endfunction
endpackage
`default_nettype wire

### hw/rtl/aaou_if.sv
// Valid/ready channel interface carrying one payload.
`default_nettype none
interface aaou_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/aaou_cordic.sv
// Iterative CORDIC producing rounded cosine and sine of a turn fraction.
`default_nettype none
module aaou_cordic import aaou_pkg::*; #(
  parameter int FRAC_BITS    = 14,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [15:0] angle,
  output logic             done,
  output logic signed [FRAC_BITS+1:0] cos_o,
  output logic signed [FRAC_BITS+1:0] sin_o
);
  localparam int SW = $clog2(CORDIC_STEPS + 1);
  localparam int RS = CORDIC_Q - FRAC_BITS;

  logic signed [33:0] x_r, y_r, z_r;
  logic [SW-1:0]      i_r;
  logic               busy_r;
  logic [1:0]         q_r;
  logic signed [33:0] dx, dy, a, cc, ss;
  logic signed [34:0] cr, sr;

  always_comb begin
    dx = y_r >>> i_r;
    dy = x_r >>> i_r;
    a  = (i_r < 32) ? 34'(atan_lut(6'(i_r))) : '0;
    case (q_r)
      2'd0: begin cc = x_r;  ss = y_r;  end
      2'd1: begin cc = -y_r; ss = x_r;  end
      2'd2: begin cc = -x_r; ss = -y_r; end
      default: begin cc = y_r; ss = -x_r; end
    endcase
    cr = (35'(cc) + (35'sd1 <<< (RS - 1))) >>> RS;
    sr = (35'(ss) + (35'sd1 <<< (RS - 1))) >>> RS;
  end

  assign done  = busy_r && (32'(i_r) == CORDIC_STEPS);
  assign cos_o = (FRAC_BITS+2)'(cr);
  assign sin_o = (FRAC_BITS+2)'(sr);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r    <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      i_r    <= '0;
      x_r    <= 34'(CORDIC_GAIN);
      y_r    <= '0;
      z_r    <= 34'({angle[13:0], 16'h0000});
      q_r    <= angle[15:14];
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (busy_r) begin
      i_r <= i_r + 1'b1;
      if (!z_r[33]) begin
        x_r <= x_r - dx; y_r <= y_r + dy; z_r <= z_r - a;
      end else begin
        x_r <= x_r + dx; y_r <= y_r - dy; z_r <= z_r + a;
      end
    end
  end
endmodule
`default_nettype wire

### hw/rtl/aaou_mac.sv
// Shared multiply-accumulate unit with round, shift and 16-bit saturation.
`default_nettype none
module aaou_mac (
  input  wire logic               clk,
  input  wire logic               clr,
  input  wire logic               en,
  input  wire logic signed [33:0] op_a,
  input  wire logic signed [33:0] op_b,
  input  wire logic [5:0]         shift,
  output logic signed [69:0]      acc,
  output logic signed [15:0]      sat_rnd,
  output logic signed [69:0]      rnd_full
);
  logic signed [69:0] prod_r, acc_r, rsum;
  logic               add_r;

  // register the product, add it to the sum in the following cycle
  always_ff @(posedge clk) begin
    if (en) prod_r <= 70'(op_a) * 70'(op_b);
    add_r <= en;
    if (clr) acc_r <= '0;
    else if (add_r) acc_r <= acc_r + prod_r;
  end

  assign acc = acc_r;
  always_comb begin
    rsum = (shift == 0) ? acc_r : acc_r + (70'sd1 <<< (shift - 1));
    rnd_full = rsum >>> shift;
    if (rnd_full > 70'sd32767) sat_rnd = 16'sh7fff;
    else if (rnd_full < -70'sd32768) sat_rnd = -16'sh8000;
    else sat_rnd = 16'(rnd_full);
  end
endmodule
`default_nettype wire

### hw/rtl/axis_angle_orientation_update.sv
// Top level: orientation matrix store and sequencer for Rodrigues updates.
//
//  channel  dir  handshake          payload
//  in       in   in_valid/in_ready  req_t (rotate or row load)
//  out      out  out_valid/out_ready res_t (all nine entries)
//
// A load writes its row on acceptance (row 3 writes nothing), then waits for
// output. A rotate is accepted, then runs the CORDIC, the nine t*a_i*a_j
// terms (two products each), the sine terms, the nine M*R dot products and
// a write-back, plus output wait.
// Reset sets M to identity. in_ready is low from acceptance until the
// result is transferred; a stalled output holds the whole block.
`default_nettype none
module axis_angle_orientation_update import aaou_pkg::*; #(
  parameter int FRAC_BITS    = 14,
  parameter int CORDIC_STEPS = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  aaou_if.sink     in_ch,
  aaou_if.source   out_ch
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_COR = 7'b0000010, S_RT = 7'b0000100,
    S_RS = 7'b0001000, S_MM = 7'b0010000, S_WB = 7'b0100000,
    S_OUT = 7'b1000000
  } state_t;

  state_t state_r;
  req_t   req_r;
  ent_t   m_r [9];
  ent_t   mn_r [9];
  // R entries, wide enough for the unsaturated t*a_i*a_j term
  logic signed [19:0] r_r [9];
  logic signed [FRAC_BITS+1:0] c_r, s_r;
  logic [3:0] e_r;      // entry index 0..8
  logic [1:0] k_r;      // term index
  logic [1:0] ph_r;     // 0 issue, 1 product, 2 accumulate, 3 take
  logic signed [33:0] tmul_r;

  cordic_ctl_t cc;
  logic signed [FRAC_BITS+1:0] cos_w, sin_w;
  logic signed [33:0] op_a, op_b;
  logic [5:0] shift;
  logic mclr, men;
  logic signed [69:0] acc_w, rfull;
  logic signed [15:0] sat_w;

  localparam logic signed [33:0] ONE = 34'sd1 <<< FRAC_BITS;
  localparam logic signed [15:0] ONE16 =
    (FRAC_BITS >= 15) ? 16'sh7fff : 16'(1 << FRAC_BITS);

  function automatic logic signed [15:0] axis_of(input req_t r, input logic [1:0] n);
    case (n)
      2'd0: return r.axis_x;
      2'd1: return r.axis_y;
      default: return r.axis_z;
    endcase
  endfunction

  function automatic logic [3:0] ix(input logic [1:0] row, input logic [1:0] col);
    return 4'(row) * 4'd3 + 4'(col);
  endfunction

  function automatic logic signed [19:0] sat_r(input logic signed [69:0] v);
    return 20'(v > 70'sd32767 ? 70'sd32767 : v < -70'sd32768 ? -70'sd32768 : v);
  endfunction

  logic [1:0] ei, ej, ek;
  always_comb begin
    unique case (e_r)
      4'd0: begin ei = 2'd0; ej = 2'd0; end
      4'd1: begin ei = 2'd0; ej = 2'd1; end
      4'd2: begin ei = 2'd0; ej = 2'd2; end
      4'd3: begin ei = 2'd1; ej = 2'd0; end
      4'd4: begin ei = 2'd1; ej = 2'd1; end
      4'd5: begin ei = 2'd1; ej = 2'd2; end
      4'd6: begin ei = 2'd2; ej = 2'd0; end
      4'd7: begin ei = 2'd2; ej = 2'd1; end
      4'd8: begin ei = 2'd2; ej = 2'd2; end
      default: begin ei = 2'd0; ej = 2'd0; end
    endcase
    ek = 2'd3 - ei - ej;
  end

  assign cc.start = (state_r == S_IDLE) && in_ch.valid && !in_ch.data.req_type;

  aaou_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst_n, .start(cc.start), .angle(in_ch.data.turn_angle),
    .done(cc.done), .cos_o(cos_w), .sin_o(sin_w)
  );

  // operand selection for the shared multiplier
  always_comb begin
    op_a = '0; op_b = '0; shift = '0;
    unique case (state_r)
      S_RT: begin
        // t*a_i first, then times a_j
        op_a = (k_r == 0) ? (ONE - 34'(c_r)) : tmul_r;
        op_b = 34'(axis_of(req_r, (k_r == 0) ? ei : ej));
        shift = 6'(2 * FRAC_BITS);
      end
      S_RS: begin
        op_a = 34'(s_r);
        op_b = 34'(axis_of(req_r, ek));
        shift = 6'(FRAC_BITS);
      end
      S_MM: begin
        op_a = 34'(m_r[ix(ei, k_r)]);
        op_b = 34'(r_r[ix(ej, k_r)]);
        shift = 6'(FRAC_BITS);
      end
      default: ;
    endcase
  end

  assign men  = (ph_r == 2'd1);
  assign mclr = (ph_r == 2'd0);

  aaou_mac u_mac (
    .clk, .clr(mclr), .en(men), .op_a, .op_b, .shift,
    .acc(acc_w), .sat_rnd(sat_w), .rnd_full(rfull)
  );

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.data  = '{m_r[0], m_r[1], m_r[2], m_r[3], m_r[4],
                          m_r[5], m_r[6], m_r[7], m_r[8]};

  logic signed [69:0] rv;
  always_comb begin
    // diagonal adds cos, off-diagonal takes the s*a_k term
    if (ei == ej) rv = 70'(r_r[e_r]) + 70'(c_r);
    else if (ej == ei + 2'd1 || (ei == 2'd2 && ej == 2'd0))
      rv = 70'(r_r[e_r]) - rfull;
    else rv = 70'(r_r[e_r]) + rfull;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      e_r <= '0; k_r <= '0; ph_r <= '0;
      for (int n = 0; n < 9; n++)
        m_r[n] <= (n == 0 || n == 4 || n == 8) ? ONE16 : '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_ch.valid) begin
          req_r <= in_ch.data;
          if (in_ch.data.req_type) begin
            if (in_ch.data.row_index != 2'd3) begin
              m_r[ix(in_ch.data.row_index, 2'd0)] <= in_ch.data.load_x;
              m_r[ix(in_ch.data.row_index, 2'd1)] <= in_ch.data.load_y;
              m_r[ix(in_ch.data.row_index, 2'd2)] <= in_ch.data.load_z;
            end
            state_r <= S_OUT;
          end else state_r <= S_COR;
        end
        S_COR: if (cc.done) begin
          c_r <= cos_w; s_r <= sin_w;
          e_r <= '0; k_r <= '0; ph_r <= '0;
          state_r <= S_RT;
        end
        S_RT: begin
          // pass 0 forms t*a_i exactly, pass 1 multiplies by a_j and rounds
          if (ph_r == 2'd3) begin
            ph_r <= '0;
            if (k_r == 0) begin
              tmul_r <= 34'(acc_w);
              k_r <= 2'd1;
            end else begin
              k_r <= '0;
              r_r[e_r] <= 20'(rfull);
              if (e_r == 4'd8) begin
                e_r <= '0; state_r <= S_RS;
              end else e_r <= e_r + 1'b1;
            end
          end else ph_r <= ph_r + 1'b1;
        end
        S_RS: begin
          if (ph_r == 2'd3) begin
            ph_r <= '0;
            r_r[e_r] <= sat_r(rv);
            if (e_r == 4'd8) begin
              e_r <= '0; state_r <= S_MM;
            end else e_r <= e_r + 1'b1;
          end else ph_r <= ph_r + 1'b1;
        end
        S_MM: begin
          // three products accumulate; issue, multiply, add per term
          if (ph_r == 2'd2) begin
            if (k_r == 2'd2) ph_r <= 2'd3;
            else begin
              k_r <= k_r + 1'b1; ph_r <= 2'd1;
            end
          end else if (ph_r == 2'd3) begin
            mn_r[e_r] <= sat_w;
            ph_r <= '0; k_r <= '0;
            if (e_r == 4'd8) state_r <= S_WB;
            else e_r <= e_r + 1'b1;
          end else ph_r <= ph_r + 1'b1;
        end
        S_WB: begin
          for (int n = 0; n < 9; n++) m_r[n] <= mn_r[n];
          e_r <= '0;
          state_r <= S_OUT;
        end
        S_OUT: if (out_ch.ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready)
    else $error("input taken while result pending");
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("ready did not drop after transfer");
  assert property (@(posedge clk) disable iff (!rst_n)
    cc.done |-> (state_r == S_COR))
    else $error("cordic finished outside its state");
endmodule
`default_nettype wire

### tb/tb_axis_angle_orientation_update.sv
// Self-checking testbench for the axis-angle orientation update block.
`timescale 1ns / 1ps
module tb_axis_angle_orientation_update;
  import aaou_pkg::*;

  localparam int FRAC = 14;
  localparam int STEPS = 16;
  localparam int NUM_RANDOM = 1480;
  localparam int IDLE_LIMIT = 5000;
  localparam logic REQ_ROTATE = 1'b0;
  localparam logic REQ_LOAD = 1'b1;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  class OrientScoreboard;
    longint orient[9];
    res_t pending_q[$];
    int mismatches;
    longint arctan[STEPS] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                              21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                              333772, 166886, 83443, 41722, 20861};
    string names[9] = '{"m11", "m12", "m13", "m21", "m22", "m23", "m31", "m32", "m33"};

    function new();
      mismatches = 0;
      foreach (orient[i]) orient[i] = (i % 4 == 0) ? 16384 : 0;
    endfunction

    function longint round_shift(longint v, int s);
      longint r;
      r = (v + (longint'(1) <<< (s - 1))) >>> s;
      return r;
    endfunction

    function longint clamp16(longint v);
      longint r;
      r = (v > 32767) ? 32767 : (v < -32768) ? -32768 : v;
      return r;
    endfunction

    function void rotate_by(longint ax[3], logic [15:0] ang);
      longint x, y, z, dx, dy, c, s, t, v, sk, acc;
      longint rm[9];
      longint nm[9];
      x = 652032874;
      y = 0;
      z = longint'(ang[13:0]) <<< 16;
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= arctan[i];
        end else begin
          x += dx; y -= dy; z += arctan[i];
        end
      end
      case (ang[15:14])
        2'd0: begin c = x; s = y; end
        2'd1: begin c = -y; s = x; end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
      c = round_shift(c, 30 - FRAC);
      s = round_shift(s, 30 - FRAC);
      t = (longint'(1) <<< FRAC) - c;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          v = round_shift(t * ax[i] * ax[j], 2 * FRAC);
          if (i == j) v += c;
          else begin
            sk = round_shift(s * ax[3 - i - j], FRAC);
            // cyclic successor pairs take the minus sign
            if ((j - i + 3) % 3 == 1) v -= sk;
            else v += sk;
          end
          rm[i * 3 + j] = clamp16(v);
        end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += orient[i * 3 + k] * rm[j * 3 + k];
          nm[i * 3 + j] = clamp16(round_shift(acc, FRAC));
        end
      orient = nm;
    endfunction

    function void note_request(req_t rq);
      longint ax[3];
      res_t r;
      if (rq.req_type == REQ_ROTATE) begin
        ax[0] = rq.axis_x; ax[1] = rq.axis_y; ax[2] = rq.axis_z;
        rotate_by(ax, rq.turn_angle);
      end else if (rq.row_index < 2'd3) begin
        orient[rq.row_index * 3 + 0] = rq.load_x;
        orient[rq.row_index * 3 + 1] = rq.load_y;
        orient[rq.row_index * 3 + 2] = rq.load_z;
      end
      for (int i = 0; i < 9; i++) r[143 - 16 * i -: 16] = orient[i][15:0];
      pending_q.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t want;
      logic signed [15:0] w, g;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %h", got);
        return;
      end
      want = pending_q.pop_front();
      for (int i = 0; i < 9; i++) begin
        w = want[143 - 16 * i -: 16];
        g = got[143 - 16 * i -: 16];
        if (w !== g) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%s mismatch: expected %0d actual %0d", names[i], w, g);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  aaou_if #(.T(req_t)) in_ch ();
  aaou_if #(.T(res_t)) out_ch ();
  OrientScoreboard sb;
  int idle_cycles;

  axis_angle_orientation_update dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic send_req(req_t rq);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= rq;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(rq);
  endtask

  function automatic req_t make_rotate(logic signed [15:0] x, logic signed [15:0] y,
                                       logic signed [15:0] z, logic [15:0] ang);
    req_t rq;
    rq = req_t'($urandom());
    rq.load_x = 16'($urandom()); rq.load_y = 16'($urandom()); rq.load_z = 16'($urandom());
    rq.row_index = 2'($urandom());
    rq.req_type = REQ_ROTATE;
    rq.axis_x = x; rq.axis_y = y; rq.axis_z = z;
    rq.turn_angle = ang;
    return rq;
  endfunction

  function automatic req_t make_load(logic [1:0] row, logic signed [15:0] x,
                                     logic signed [15:0] y, logic signed [15:0] z);
    req_t rq;
    rq.axis_x = 16'($urandom()); rq.axis_y = 16'($urandom()); rq.axis_z = 16'($urandom());
    rq.turn_angle = 16'($urandom());
    rq.req_type = REQ_LOAD;
    rq.row_index = row;
    rq.load_x = x; rq.load_y = y; rq.load_z = z;
    return rq;
  endfunction

  task automatic load_identity();
    send_req(make_load(2'd0, ONE_Q14, 16'sd0, 16'sd0));
    send_req(make_load(2'd1, 16'sd0, ONE_Q14, 16'sd0));
    send_req(make_load(2'd2, 16'sd0, 16'sd0, ONE_Q14));
  endtask

  // random unit axis, rounded to Q1.14
  function automatic req_t random_unit_rotate();
    real v[3];
    real n;
    logic signed [15:0] q[3];
    n = 0.0;
    for (int i = 0; i < 3; i++) begin
      v[i] = real'($urandom_range(0, 2000)) - 1000.0;
      n += v[i] * v[i];
    end
    if (n < 1.0) begin
      v[0] = 1.0; n = 1.0;
    end
    n = $sqrt(n);
    for (int i = 0; i < 3; i++)
      q[i] = 16'($rtoi(v[i] / n * 16384.0 + (v[i] < 0 ? -0.5 : 0.5)));
    return make_rotate(q[0], q[1], q[2], 16'($urandom()));
  endfunction

  // receive side
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      int stall;
      stall = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_result(out_ch.data);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("FAIL axis_angle_orientation_update");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int r;
    sb = new();
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: quadrant edges, axis extremes, loads, ignored row
    send_req(make_rotate(16'sd0, 16'sd0, ONE_Q14, 16'd0));
    send_req(make_rotate(16'sd0, 16'sd0, ONE_Q14, 16'd16384));
    send_req(make_rotate(ONE_Q14, 16'sd0, 16'sd0, 16'd32768));
    send_req(make_rotate(16'sd0, -16'sd16384, 16'sd0, 16'd49152));
    send_req(make_rotate(-16'sd16384, 16'sd0, 16'sd0, 16'd65535));
    send_req(make_rotate(16'sd0, 16'sd0, -16'sd16384, 16'd8192));
    send_req(make_rotate(16'sd9459, 16'sd9459, 16'sd9459, 16'd21845));
    send_req(make_load(2'd3, 16'sd1234, -16'sd1234, 16'sd77));
    send_req(make_load(2'd0, 16'sh7fff, 16'sh8000, 16'sd0));
    send_req(make_load(2'd1, 16'sh8000, 16'sh7fff, 16'sh7fff));
    send_req(make_load(2'd2, 16'sh7fff, 16'sh8000, 16'sh8000));
    send_req(make_rotate(16'sd0, ONE_Q14, 16'sd0, 16'd12000));
    // non-unit axis drives saturation
    send_req(make_rotate(16'sh8000, 16'sh7fff, 16'sh8000, 16'd40000));
    send_req(make_rotate(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'd30000));
    send_req(make_rotate(16'sd0, 16'sd0, 16'sd0, 16'd5000));
    load_identity();
    send_req(make_rotate(16'sd0, 16'sd0, ONE_Q14, 16'd1));

    // hold until the block has drained
    while (sb.pending_q.size() != 0) @(posedge clk);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      r = $urandom_range(0, 99);
      if (r < 70) send_req(random_unit_rotate());
      else if (r < 78)
        send_req(make_rotate(16'($urandom()), 16'($urandom()), 16'($urandom()),
                             16'($urandom())));
      else if (r < 83) load_identity();
      else send_req(make_load(2'($urandom()), 16'($urandom()), 16'($urandom()),
                              16'($urandom())));
    end
    in_ch.valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("PASS axis_angle_orientation_update");
    else
      $display("FAIL axis_angle_orientation_update");
    $finish;
  end
endmodule
